>>> rtl/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// types, codes and constants shared by the character lcd bus sequencer
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   localparam int POLL_COUNT_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT     = 4;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FUNCTION_SET    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRY_MODE      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_CONTROL = 2'd2;

   localparam logic [7:0] FUNCTION_SET_RESET    = 8'd40;
   localparam logic [7:0] ENTRY_MODE_RESET      = 8'd6;
   localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'd14;

   localparam logic [1:0] FUNC_INIT        = 2'd0;
   localparam logic [1:0] FUNC_INSTRUCTION = 2'd1;
   localparam logic [1:0] FUNC_DATA        = 2'd2;
   localparam logic [1:0] FUNC_BUSY        = 2'd3;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_WAIT   = 2'd2;
   localparam logic [1:0] OP_REJECT = 2'd3;

   // burst kinds handed from the front to the back
   localparam logic [2:0] KIND_REJECT     = 3'd0;
   localparam logic [2:0] KIND_READ       = 3'd1;
   localparam logic [2:0] KIND_INIT       = 3'd2;
   localparam logic [2:0] KIND_WRITE      = 3'd3;
   localparam logic [2:0] KIND_WRITE_READ = 3'd4;

   localparam logic [7:0] WORD_DISPLAY_OFF = 8'h08;
   localparam logic [7:0] WORD_CLEAR       = 8'h01;
   localparam logic [3:0] NIB_FS8          = 4'h3;
   localparam logic [3:0] NIB_FS4          = 4'h2;
   localparam logic [6:0] WAIT_POWER       = 7'd50;
   localparam logic [6:0] WAIT_SECOND      = 7'd100;
   localparam logic [6:0] WAIT_SHORT       = 7'd10;

   localparam logic [3:0] INIT_LAST_STEP = 4'd8;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] byte_value;
      logic       busy_flag;
   } lcdseq_req_type;

   typedef struct packed {
      logic [1:0] bus_op;
      logic       reg_select;
      logic [3:0] nibble_out;
      logic [6:0] wait_ms;
      logic       last;
   } lcdseq_rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] byte_value;
      logic       reg_select;
   } lcdseq_burst_type;

   localparam int BURST_BITS = $bits(lcdseq_burst_type);

endpackage

>>> rtl/lcdseq_queue.sv
// ----------------------------------------------------------------------------
// lcdseq_queue
// small register fifo between the command front and the bus back end
// ----------------------------------------------------------------------------
module lcdseq_queue #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(DEPTH);

   logic [WIDTH-1:0]      store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == COUNT_MAX);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/lcdseq_front.sv
// ----------------------------------------------------------------------------
// lcdseq_front
// accepts commands and busy responses, tracks the transfer state and
// queues one burst descriptor per item that causes results
// ----------------------------------------------------------------------------
module lcdseq_front #(
   parameter int POLL_COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lcdseq_pkg::lcdseq_req_type            req_data,
   input  logic                                  csr_write_enable,
   input  logic [lcdseq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lcdseq_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                                  queue_full,
   output logic                                  burst_push,
   output lcdseq_pkg::lcdseq_burst_type          burst_data
);
   import lcdseq_pkg::*;

   logic [7:0]                 function_set_ff, entry_mode_ff, display_control_ff;
   logic                       phase_ff, phase_in;
   logic [7:0]                 pending_byte_ff, pending_byte_in;
   logic                       pending_select_ff, pending_select_in;
   logic [POLL_COUNT_BITS-1:0] poll_count_ff, poll_count_in;
   logic [2:0]                 init_index_ff, init_index_in;
   logic [POLL_COUNT_BITS-1:0] poll_next;
   logic                       accept;

   function automatic logic [7:0] init_word(input logic [2:0] k,
                                            input logic [7:0] fs,
                                            input logic [7:0] em,
                                            input logic [7:0] dc);
      logic [7:0] w;
      unique case (k)
         3'd1:    w = fs;
         3'd2:    w = WORD_DISPLAY_OFF;
         3'd3:    w = WORD_CLEAR;
         3'd4:    w = em;
         default: w = dc;
      endcase
      return w;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign poll_next = poll_count_ff + 1'b1;

   always_comb begin
      phase_in              = phase_ff;
      pending_byte_in       = pending_byte_ff;
      pending_select_in     = pending_select_ff;
      poll_count_in         = poll_count_ff;
      init_index_in         = init_index_ff;
      burst_push            = 1'b0;
      burst_data.kind       = KIND_REJECT;
      burst_data.byte_value = pending_byte_ff;
      burst_data.reg_select = pending_select_ff;
      if (accept) begin
         if (req_data.func != FUNC_BUSY) begin
            burst_push = 1'b1;
            if (phase_ff) begin
               burst_data.kind = KIND_REJECT;
            end else if (req_data.func == FUNC_INIT) begin
               burst_data.kind   = KIND_INIT;
               init_index_in     = 3'd1;
               pending_byte_in   = function_set_ff;
               pending_select_in = 1'b0;
               poll_count_in     = '0;
               phase_in          = 1'b1;
            end else begin
               burst_data.kind   = KIND_READ;
               init_index_in     = 3'd0;
               pending_byte_in   = req_data.byte_value;
               pending_select_in = (req_data.func == FUNC_DATA);
               poll_count_in     = '0;
               phase_in          = 1'b1;
            end
         end else if (phase_ff) begin
            burst_push    = 1'b1;
            poll_count_in = poll_next;
            if (req_data.busy_flag && (poll_next != '0)) begin
               burst_data.kind = KIND_READ;
            end else if (init_index_ff >= 3'd1 && init_index_ff <= 3'd4) begin
               burst_data.kind   = KIND_WRITE_READ;
               init_index_in     = init_index_ff + 3'd1;
               pending_byte_in   = init_word(init_index_ff + 3'd1, function_set_ff,
                                             entry_mode_ff, display_control_ff);
               pending_select_in = 1'b0;
               poll_count_in     = '0;
            end else begin
               burst_data.kind = KIND_WRITE;
               init_index_in   = 3'd0;
               phase_in        = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= 1'b0;
         pending_byte_ff   <= '0;
         pending_select_ff <= 1'b0;
         poll_count_ff     <= '0;
         init_index_ff     <= '0;
      end else begin
         phase_ff          <= phase_in;
         pending_byte_ff   <= pending_byte_in;
         pending_select_ff <= pending_select_in;
         poll_count_ff     <= poll_count_in;
         init_index_ff     <= init_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         function_set_ff    <= FUNCTION_SET_RESET;
         entry_mode_ff      <= ENTRY_MODE_RESET;
         display_control_ff <= DISPLAY_CONTROL_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_FUNCTION_SET) begin
            function_set_ff <= csr_write_data;
         end
         if (csr_index == CSR_ENTRY_MODE) begin
            entry_mode_ff <= csr_write_data;
         end
         if (csr_index == CSR_DISPLAY_CONTROL) begin
            display_control_ff <= csr_write_data;
         end
      end
   end

endmodule

>>> rtl/lcdseq_back.sv
// ----------------------------------------------------------------------------
// lcdseq_back
// expands the burst at the head of the queue into bus operations,
// one per transfer on the result channel
// ----------------------------------------------------------------------------
module lcdseq_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_empty,
   input  lcdseq_pkg::lcdseq_burst_type head_data,
   output logic                         queue_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lcdseq_pkg::lcdseq_rsp_type   rsp_data
);
   import lcdseq_pkg::*;

   logic [3:0] step_ff, step_in;
   logic       fire;

   assign rsp_valid = !queue_empty;
   assign fire      = rsp_valid && rsp_ready;
   assign queue_pop = fire && rsp_data.last;

   always_comb begin
      rsp_data = '0;
      unique case (head_data.kind)
         KIND_REJECT: begin
            rsp_data.bus_op = OP_REJECT;
            rsp_data.last   = 1'b1;
         end
         KIND_READ: begin
            rsp_data.bus_op = OP_READ;
            rsp_data.last   = 1'b1;
         end
         KIND_INIT: begin
            unique case (step_ff)
               4'd0: begin
                  rsp_data.bus_op  = OP_WAIT;
                  rsp_data.wait_ms = WAIT_POWER;
               end
               4'd2: begin
                  rsp_data.bus_op  = OP_WAIT;
                  rsp_data.wait_ms = WAIT_SECOND;
               end
               4'd4, 4'd6: begin
                  rsp_data.bus_op  = OP_WAIT;
                  rsp_data.wait_ms = WAIT_SHORT;
               end
               4'd1, 4'd3, 4'd5: begin
                  rsp_data.bus_op     = OP_WRITE;
                  rsp_data.nibble_out = NIB_FS8;
               end
               4'd7: begin
                  rsp_data.bus_op     = OP_WRITE;
                  rsp_data.nibble_out = NIB_FS4;
               end
               default: begin
                  rsp_data.bus_op = OP_READ;
                  rsp_data.last   = 1'b1;
               end
            endcase
         end
         KIND_WRITE, KIND_WRITE_READ: begin
            if (step_ff == 4'd0) begin
               rsp_data.bus_op     = OP_WRITE;
               rsp_data.reg_select = head_data.reg_select;
               rsp_data.nibble_out = head_data.byte_value[7:4];
            end else if (step_ff == 4'd1) begin
               rsp_data.bus_op     = OP_WRITE;
               rsp_data.reg_select = head_data.reg_select;
               rsp_data.nibble_out = head_data.byte_value[3:0];
               rsp_data.last       = (head_data.kind == KIND_WRITE);
            end else begin
               rsp_data.bus_op = OP_READ;
               rsp_data.last   = 1'b1;
            end
         end
         default: begin
            rsp_data.bus_op = OP_REJECT;
            rsp_data.last   = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (fire) begin
         step_in = rsp_data.last ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> rtl/char_lcd_4bit_bus_sequencer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_bus_sequencer_top
// bus operation sequencer for a character lcd on a 4-bit interface
// ----------------------------------------------------------------------------
// A command or busy response is taken whenever the burst queue (QUEUE_DEPTH
// entries) has room, independent of the result side. Each item turns into a
// burst of 0 to 9 results: stray busy response none, reject 1, busy read 1,
// nibble pair 2, nibble pair plus next read 3, init 9. The back end emits one
// result per cycle while rsp_ready is high, and an item holds the result
// channel until its last result is taken. Configuration writes take effect at
// the next clock edge.
module char_lcd_4bit_bus_sequencer_top #(
   parameter int POLL_COUNT_BITS = lcdseq_pkg::POLL_COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH     = lcdseq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lcdseq_pkg::lcdseq_req_type            req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lcdseq_pkg::lcdseq_rsp_type            rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [lcdseq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lcdseq_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import lcdseq_pkg::*;

   logic                  queue_full, queue_empty, queue_pop, burst_push;
   lcdseq_burst_type      burst_data, head_burst;
   logic [BURST_BITS-1:0] head_bits;

   lcdseq_front #(
      .POLL_COUNT_BITS(POLL_COUNT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .queue_full      (queue_full),
      .burst_push      (burst_push),
      .burst_data      (burst_data)
   );

   lcdseq_queue #(
      .WIDTH(BURST_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (burst_push),
      .push_data(burst_data),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head_data(head_bits)
   );

   assign head_burst = lcdseq_burst_type'(head_bits);

   lcdseq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_empty(queue_empty),
      .head_data  (head_burst),
      .queue_pop  (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> test/char_lcd_4bit_bus_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_bus_sequencer_top_tb
// Self-checking bench for the 4-bit character lcd bus sequencer. A table of
// directed commands covers reset defaults, rejects, stray busy answers and a
// full init. Random command/poll sequences with some noise follow under
// several register settings, one of them with no idling on either side.
// Every burst is predicted in the bench and compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module char_lcd_4bit_bus_sequencer_top_tb;
   import lcdseq_pkg::*;

   localparam int IDLE_PCT         = 37;
   localparam int NOISE_PCT        = 10;
   localparam int INIT_PCT         = 12;
   localparam int RANDOM_PER_PHASE = 42;
   localparam int DRAIN_CYCLES     = 32;
   localparam int STALL_LIMIT      = 1000;
   localparam int POLL_BITS        = POLL_COUNT_BITS_DEFAULT;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} check_kind_type;

   typedef struct packed {
      check_kind_type kind;
      lcdseq_rsp_type rsp;
   } check_plan_type;

   typedef struct packed {
      lcdseq_req_type req;
      check_plan_type plan;
   } stim_row_type;

   localparam lcdseq_rsp_type RSP_READ =
      '{bus_op: OP_READ, reg_select: 1'b0, nibble_out: 4'd0, wait_ms: 7'd0, last: 1'b1};
   localparam lcdseq_rsp_type RSP_REJECT =
      '{bus_op: OP_REJECT, reg_select: 1'b0, nibble_out: 4'd0, wait_ms: 7'd0, last: 1'b1};
   localparam lcdseq_rsp_type RSP_NOTHING = '0;
   localparam check_plan_type PLAN_MODEL  = '{kind: CHECK_MODEL, rsp: RSP_NOTHING};

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   lcdseq_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   lcdseq_rsp_type rsp_data;
   logic           csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   // predictor state
   logic [7:0]           shadow_function_set    = FUNCTION_SET_RESET;
   logic [7:0]           shadow_entry_mode      = ENTRY_MODE_RESET;
   logic [7:0]           shadow_display_control = DISPLAY_CONTROL_RESET;
   logic                 seq_active = 1'b0;
   logic [7:0]           seq_byte = '0;
   logic                 seq_select = 1'b0;
   logic [POLL_BITS-1:0] seq_polls = '0;
   logic [2:0]           seq_init_step = '0;

   lcdseq_rsp_type step_ops [$];
   lcdseq_rsp_type pending_bus_ops [$];
   check_plan_type check_plans [$];
   stim_row_type   directed_rows [$];

   int  errors = 0;
   int  req_transfers = 0;
   int  rsp_transfers = 0;
   int  random_items = 0;
   int  settings_used = 1;
   int  stall_cycles = 0;
   bit  quiet = 1'b0;

   char_lcd_4bit_bus_sequencer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic void add_op(logic [1:0] op, logic rs, logic [3:0] nib, logic [6:0] ms);
      lcdseq_rsp_type r;
      r = '{bus_op: op, reg_select: rs, nibble_out: nib, wait_ms: ms, last: 1'b0};
      step_ops.push_back(r);
   endfunction

   function automatic logic [7:0] init_instruction(logic [2:0] k);
      case (k)
         3'd1: return shadow_function_set;
         3'd2: return WORD_DISPLAY_OFF;
         3'd3: return WORD_CLEAR;
         3'd4: return shadow_entry_mode;
         default: return shadow_display_control;
      endcase
   endfunction

   function automatic void start_transfer(logic [7:0] value, logic rs);
      seq_byte   = value;
      seq_select = rs;
      seq_polls  = '0;
      seq_active = 1'b1;
   endfunction

   // bus operations caused by one accepted command or busy answer
   function automatic void predict_bus_ops(lcdseq_req_type item);
      step_ops.delete();
      if (item.func != FUNC_BUSY) begin
         if (seq_active) begin
            add_op(OP_REJECT, 1'b0, 4'd0, 7'd0);
         end else if (item.func == FUNC_INIT) begin
            add_op(OP_WAIT, 1'b0, 4'd0, WAIT_POWER);
            add_op(OP_WRITE, 1'b0, NIB_FS8, 7'd0);
            add_op(OP_WAIT, 1'b0, 4'd0, WAIT_SECOND);
            add_op(OP_WRITE, 1'b0, NIB_FS8, 7'd0);
            add_op(OP_WAIT, 1'b0, 4'd0, WAIT_SHORT);
            add_op(OP_WRITE, 1'b0, NIB_FS8, 7'd0);
            add_op(OP_WAIT, 1'b0, 4'd0, WAIT_SHORT);
            add_op(OP_WRITE, 1'b0, NIB_FS4, 7'd0);
            seq_init_step = 3'd1;
            start_transfer(init_instruction(seq_init_step), 1'b0);
            add_op(OP_READ, 1'b0, 4'd0, 7'd0);
         end else begin
            seq_init_step = 3'd0;
            start_transfer(item.byte_value, item.func == FUNC_DATA);
            add_op(OP_READ, 1'b0, 4'd0, 7'd0);
         end
      end else if (seq_active) begin
         seq_polls = seq_polls + 1'b1;
         if (item.busy_flag && seq_polls != '0) begin
            add_op(OP_READ, 1'b0, 4'd0, 7'd0);
         end else begin
            add_op(OP_WRITE, seq_select, seq_byte[7:4], 7'd0);
            add_op(OP_WRITE, seq_select, seq_byte[3:0], 7'd0);
            if (seq_init_step >= 3'd1 && seq_init_step <= 3'd4) begin
               seq_init_step = seq_init_step + 3'd1;
               start_transfer(init_instruction(seq_init_step), 1'b0);
               add_op(OP_READ, 1'b0, 4'd0, 7'd0);
            end else begin
               seq_init_step = 3'd0;
               seq_active    = 1'b0;
            end
         end
      end
      if (step_ops.size() > 0) step_ops[step_ops.size() - 1].last = 1'b1;
   endfunction

   function automatic stim_row_type stim(logic [1:0] func, logic [7:0] value, logic busy,
                                         check_kind_type kind, lcdseq_rsp_type rsp);
      stim_row_type r;
      r.req  = '{func: func, byte_value: value, busy_flag: busy};
      r.plan = '{kind: kind, rsp: rsp};
      return r;
   endfunction

   // request and response checking
   always @(posedge clock) begin : monitor
      check_plan_type plan;
      lcdseq_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_transfers++;
            plan = check_plans.pop_front();
            predict_bus_ops(req_data);
            case (plan.kind)
               CHECK_MODEL: foreach (step_ops[i]) pending_bus_ops.push_back(step_ops[i]);
               CHECK_TYPED: pending_bus_ops.push_back(plan.rsp);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            rsp_transfers++;
            if (pending_bus_ops.size() == 0) begin
               $error("unexpected response transfer %p", rsp_data);
               errors++;
            end else begin
               want = pending_bus_ops.pop_front();
               if (rsp_data.bus_op !== want.bus_op) begin
                  $error("bus_op expected %0d got %0d", want.bus_op, rsp_data.bus_op);
                  errors++;
               end
               if (rsp_data.reg_select !== want.reg_select) begin
                  $error("reg_select expected %0d got %0d", want.reg_select,
                         rsp_data.reg_select);
                  errors++;
               end
               if (rsp_data.nibble_out !== want.nibble_out) begin
                  $error("nibble_out expected %0d got %0d", want.nibble_out,
                         rsp_data.nibble_out);
                  errors++;
               end
               if (rsp_data.wait_ms !== want.wait_ms) begin
                  $error("wait_ms expected %0d got %0d", want.wait_ms, rsp_data.wait_ms);
                  errors++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_data.last);
                  errors++;
               end
            end
         end
      end
   end

   // response side stalls
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("char_lcd_4bit_bus_sequencer_top_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(input lcdseq_req_type item, input check_plan_type plan);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      check_plans.push_back(plan);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_in_sequence(input lcdseq_req_type item);
      lcdseq_req_type noise;
      if ($urandom_range(99) < NOISE_PCT) begin
         noise.func       = 2'($urandom_range(3));
         noise.byte_value = 8'($urandom_range(255));
         noise.busy_flag  = 1'($urandom_range(1));
         send_item(noise, PLAN_MODEL);
      end
      send_item(item, PLAN_MODEL);
      random_items++;
   endtask

   // one command with its busy polling, or a full init
   task automatic run_transaction();
      lcdseq_req_type item;
      int             steps;
      item.byte_value = 8'($urandom_range(255));
      item.busy_flag  = 1'($urandom_range(1));
      if ($urandom_range(99) < INIT_PCT) begin
         item.func = FUNC_INIT;
         steps     = 5;
      end else begin
         item.func = $urandom_range(1) ? FUNC_DATA : FUNC_INSTRUCTION;
         steps     = 1;
      end
      send_in_sequence(item);
      repeat (steps) begin
         item.func = FUNC_BUSY;
         repeat ($urandom_range(3)) begin
            item.byte_value = 8'($urandom_range(255));
            item.busy_flag  = 1'b1;
            send_in_sequence(item);
         end
         item.byte_value = 8'($urandom_range(255));
         item.busy_flag  = 1'b0;
         send_in_sequence(item);
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_bus_ops.size() != 0 || check_plans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CSR_FUNCTION_SET:    shadow_function_set    = value;
         CSR_ENTRY_MODE:      shadow_entry_mode      = value;
         CSR_DISPLAY_CONTROL: shadow_display_control = value;
         default: ;
      endcase
   endtask

   task automatic program_settings(input logic [7:0] fs, input logic [7:0] em,
                                   input logic [7:0] dc);
      wait_quiet();
      write_register(CSR_FUNCTION_SET, fs);
      write_register(CSR_ENTRY_MODE, em);
      write_register(CSR_UNUSED, 8'($urandom_range(255)));
      write_register(CSR_DISPLAY_CONTROL, dc);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      directed_rows = '{
         stim(FUNC_BUSY,        8'h00, 1'b1, CHECK_NONE,  RSP_NOTHING),
         stim(FUNC_BUSY,        8'hFF, 1'b0, CHECK_NONE,  RSP_NOTHING),
         stim(FUNC_INSTRUCTION, 8'h00, 1'b0, CHECK_TYPED, RSP_READ),
         stim(FUNC_INSTRUCTION, 8'hFF, 1'b1, CHECK_TYPED, RSP_REJECT),
         stim(FUNC_DATA,        8'hA5, 1'b0, CHECK_TYPED, RSP_REJECT),
         stim(FUNC_INIT,        8'h00, 1'b0, CHECK_TYPED, RSP_REJECT),
         stim(FUNC_BUSY,        8'h00, 1'b1, CHECK_TYPED, RSP_READ),
         stim(FUNC_BUSY,        8'h00, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_DATA,        8'hFF, 1'b0, CHECK_TYPED, RSP_READ),
         stim(FUNC_BUSY,        8'hFF, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_DATA,        8'h00, 1'b1, CHECK_TYPED, RSP_READ),
         stim(FUNC_BUSY,        8'h5A, 1'b1, CHECK_TYPED, RSP_READ),
         stim(FUNC_BUSY,        8'h00, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_INIT,        8'hFF, 1'b1, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_INIT,        8'h00, 1'b0, CHECK_TYPED, RSP_REJECT),
         stim(FUNC_BUSY,        8'h00, 1'b1, CHECK_TYPED, RSP_READ),
         stim(FUNC_BUSY,        8'h00, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_BUSY,        8'hFF, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_DATA,        8'h5A, 1'b0, CHECK_TYPED, RSP_REJECT),
         stim(FUNC_BUSY,        8'h00, 1'b1, CHECK_TYPED, RSP_READ),
         stim(FUNC_BUSY,        8'h00, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_BUSY,        8'h00, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_BUSY,        8'h00, 1'b0, CHECK_MODEL, RSP_NOTHING),
         stim(FUNC_BUSY,        8'h00, 1'b1, CHECK_NONE,  RSP_NOTHING),
         stim(FUNC_INSTRUCTION, 8'h3C, 1'b0, CHECK_TYPED, RSP_READ)
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_item(directed_rows[i].req, directed_rows[i].plan);

      for (int phase_num = 0; phase_num < 4; phase_num++) begin
         case (phase_num)
            0: program_settings(8'h00, 8'h00, 8'h00);
            1: program_settings(8'hFF, 8'hFF, 8'hFF);
            default: program_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                      8'($urandom_range(255)));
         endcase
         // no idling on either side through the second setting
         quiet = (phase_num == 1);
         while (random_items < (phase_num + 1) * RANDOM_PER_PHASE) run_transaction();
         quiet = 1'b0;
      end

      wait_quiet();
      $display("%0d request and %0d response transfers checked under %0d register settings,",
               req_transfers, rsp_transfers, settings_used);
      $display("including rejects, stray busy answers, init bursts and a stretch without idling");
      if (errors == 0) begin
         $display("char_lcd_4bit_bus_sequencer_top_tb passed");
      end else begin
         $display("char_lcd_4bit_bus_sequencer_top_tb failed");
      end
      $finish;
   end

endmodule
